// File: rtl/core/iirt_pkg.sv
// Shared types, constants and control bundle for the transposed IIR filter.
package iirt_pkg;

  // Filter order, one tap cell per delay element.
  localparam int ORDER = 2;

  // Field and internal widths.
  localparam int SAMPLE_W = 16;
  localparam int COEF_W   = 18;
  localparam int PROD_W   = SAMPLE_W + COEF_W;
  localparam int DELAY_W  = 40;
  localparam int REG_IDX_W = 3;
  localparam int FRAC_SHIFT = 15;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [COEF_W-1:0]   coef_t;
  typedef logic signed [PROD_W-1:0]   prod_t;
  typedef logic signed [DELAY_W-1:0]  delay_t;
  typedef logic [REG_IDX_W-1:0]       reg_idx_t;

  // Register indexes of the configuration port.
  localparam reg_idx_t REG_FF_COEF_0   = 3'd0;
  localparam reg_idx_t REG_FF_COEF_1   = 3'd1;
  localparam reg_idx_t REG_FF_COEF_2   = 3'd2;
  localparam reg_idx_t REG_FB_COEF_1   = 3'd3;
  localparam reg_idx_t REG_FB_COEF_2   = 3'd4;
  localparam reg_idx_t REG_FB_ENABLE   = 3'd5;

  // Reset value of b0 (1.0 in Q2.15).
  localparam coef_t FF_COEF_0_RESET = 18'sd32768;

  // Saturation limits.
  localparam sample_t SAMPLE_MAX = 16'sh7fff;
  localparam sample_t SAMPLE_MIN = 16'sh8000;
  localparam delay_t  DELAY_MAX  = {1'b0, {(DELAY_W-1){1'b1}}};
  localparam delay_t  DELAY_MIN  = {1'b1, {(DELAY_W-1){1'b0}}};

  // Rounding constant for the Q.30 to Q.15 step (round half up).
  localparam int RND_W = DELAY_W + 2;
  localparam logic signed [RND_W-1:0] ROUND_HALF = RND_W'(1) <<< (FRAC_SHIFT - 1);

  // Strobes that step every stage of the datapath.
  typedef struct packed {
    logic load;    // sample beat taken, multiply by the forward coefficients
    logic shift;   // output computed, neighbour delay folded into each cell
    logic update;  // feedback term applied, delay registers written
  } iirt_ctrl_t;

endpackage

// File: rtl/core/iirt_tap_cell.sv
// One tap cell of the transposed structure: holds one delay element.
module iirt_tap_cell (
  input  logic            clk,
  input  logic            rst_n,
  input  iirt_pkg::iirt_ctrl_t ctrl,
  input  iirt_pkg::sample_t    x_in,
  input  iirt_pkg::sample_t    y_in,
  input  iirt_pkg::coef_t      ff_coef,
  input  iirt_pkg::coef_t      fb_coef,
  input  logic            fb_en,
  input  iirt_pkg::delay_t     d_next,
  output iirt_pkg::delay_t     d_out
);
  import iirt_pkg::*;

  localparam int PART_W = DELAY_W + 1;

  prod_t                     bx_r;
  prod_t                     bx_nxt;
  logic signed [PART_W-1:0]  part_r;
  logic signed [PART_W-1:0]  part_nxt;
  delay_t                    d_r;
  delay_t                    d_nxt;
  prod_t                     ay;
  logic signed [RND_W-1:0]   v;

  // Forward product of the new sample.
  assign bx_nxt = ff_coef * x_in;

  // Fold in the neighbour's delay while it still holds the previous value.
  assign part_nxt = PART_W'(bx_r) + PART_W'(d_next);

  // Feedback product on the output sample, then clamp to the delay range.
  assign ay = fb_coef * y_in;

  always_comb begin
    v = RND_W'(part_r) - (fb_en ? RND_W'(ay) : RND_W'(0));
    if (v > RND_W'(DELAY_MAX)) begin
      d_nxt = DELAY_MAX;
    end else if (v < RND_W'(DELAY_MIN)) begin
      d_nxt = DELAY_MIN;
    end else begin
      d_nxt = v[DELAY_W-1:0];
    end
  end

  // Product and partial sum registers carry no reset.
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      bx_r <= bx_nxt;
    end
    if (ctrl.shift) begin
      part_r <= part_nxt;
    end
  end

  // The delay element is filter state and clears at reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_r <= '0;
    end else if (ctrl.update) begin
      d_r <= d_nxt;
    end
  end

  assign d_out = d_r;

endmodule

// File: rtl/core/iirt_head.sv
// Output end of the chain: b0 product, rounding, saturation and result register.
module iirt_head (
  input  logic            clk,
  input  logic            rst_n,
  input  iirt_pkg::iirt_ctrl_t ctrl,
  input  iirt_pkg::sample_t    x_in,
  input  iirt_pkg::coef_t      ff_coef_0,
  input  iirt_pkg::delay_t     d0_in,
  input  logic            out_ready,
  output logic            out_valid,
  output iirt_pkg::sample_t    y_out,
  output logic            sat_out
);
  import iirt_pkg::*;

  localparam int YW_W = RND_W - FRAC_SHIFT;

  prod_t                    p0_r;
  prod_t                    p0_nxt;
  logic signed [RND_W-1:0]  acc;
  logic signed [YW_W-1:0]   yw;
  sample_t                  y_r;
  sample_t                  y_nxt;
  logic                     sat_r;
  logic                     sat_nxt;
  logic                     out_valid_r;
  logic                     out_valid_nxt;

  assign p0_nxt = ff_coef_0 * x_in;

  // Add the first delay, round half up and clip to the sample range.
  always_comb begin
    acc = RND_W'(p0_r) + RND_W'(d0_in) + ROUND_HALF;
    yw  = acc[RND_W-1:FRAC_SHIFT];
    if (yw > YW_W'(SAMPLE_MAX)) begin
      y_nxt   = SAMPLE_MAX;
      sat_nxt = 1'b1;
    end else if (yw < YW_W'(SAMPLE_MIN)) begin
      y_nxt   = SAMPLE_MIN;
      sat_nxt = 1'b1;
    end else begin
      y_nxt   = yw[SAMPLE_W-1:0];
      sat_nxt = 1'b0;
    end
  end

  // Payload registers; the result stays put until the next output is formed.
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      p0_r <= p0_nxt;
    end
    if (ctrl.shift) begin
      y_r   <= y_nxt;
      sat_r <= sat_nxt;
    end
  end

  // Result beat valid flag.
  always_comb begin
    if (ctrl.shift) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign y_out     = y_r;
  assign sat_out   = sat_r;

endmodule

// File: rtl/core/iir_filter_transposed_unit.sv
// Top level of the transposed direct form II IIR filter.
//
// A sample beat enters on in_valid/in_ready and one filtered sample leaves on
// out_valid/out_ready with a flag that marks clipping. Coefficients and the
// feedback enable are written through the cfg_ channel (index, data), which
// is always ready; write it only while the filter is idle.
// The result is written to the output register by the output stage that
// follows its sample beat's multiply stage, once the previous sample's delay
// update is done and the output register is free. Output stages of
// successive samples never run back to back: the first delay element can only
// be used by the next sample once the feedback product on the current output
// has been subtracted, which takes the cycle after the output is formed.
// Datapath: a head stage forms the output, then a row of tap cells, one per
// delay element, each adding its neighbour's delay less its own feedback term.
// Reset clears the delay line, restores b0 to 1.0, the other coefficients to
// zero and enables feedback. A stalled receiver holds the result in the
// output register; one further sample beat is taken into the multiply stage
// and then in_ready drops until the result is taken.
module iir_filter_transposed_unit (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  iirt_pkg::sample_t    in_sample_in,
  output logic                 out_valid,
  input  logic                 out_ready,
  output iirt_pkg::sample_t    out_sample_out,
  output logic                 out_saturated,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  iirt_pkg::reg_idx_t   cfg_index,
  input  iirt_pkg::coef_t      cfg_data
);
  import iirt_pkg::*;

  coef_t       ff_coef_r [0:2];
  coef_t       fb_coef_r [1:2];
  logic        fb_en_r;
  logic        s1_v_r;
  logic        s1_v_nxt;
  logic        s2_v_r;
  iirt_ctrl_t  ctrl;
  delay_t      d_link [0:ORDER];
  logic        cfg_wr;

  // Configuration register file.
  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ff_coef_r[0] <= FF_COEF_0_RESET;
      ff_coef_r[1] <= '0;
      ff_coef_r[2] <= '0;
      fb_coef_r[1] <= '0;
      fb_coef_r[2] <= '0;
      fb_en_r      <= 1'b1;
    end else if (cfg_wr) begin
      unique case (cfg_index)
        REG_FF_COEF_0: ff_coef_r[0] <= cfg_data;
        REG_FF_COEF_1: ff_coef_r[1] <= cfg_data;
        REG_FF_COEF_2: ff_coef_r[2] <= cfg_data;
        REG_FB_COEF_1: fb_coef_r[1] <= cfg_data;
        REG_FB_COEF_2: fb_coef_r[2] <= cfg_data;
        REG_FB_ENABLE: fb_en_r      <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Stage control: multiply stage, output stage, delay update stage.
  always_comb begin
    ctrl.shift  = s1_v_r && !s2_v_r && (!out_valid || out_ready);
    ctrl.update = s2_v_r;
    in_ready    = !s1_v_r || ctrl.shift;
    ctrl.load   = in_valid && in_ready;
    if (ctrl.load) begin
      s1_v_nxt = 1'b1;
    end else if (ctrl.shift) begin
      s1_v_nxt = 1'b0;
    end else begin
      s1_v_nxt = s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      s1_v_r <= s1_v_nxt;
      s2_v_r <= ctrl.shift;
    end
  end

  // Output end of the chain.
  iirt_head u_head (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (ctrl),
    .x_in      (in_sample_in),
    .ff_coef_0 (ff_coef_r[0]),
    .d0_in     (d_link[0]),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .y_out     (out_sample_out),
    .sat_out   (out_saturated)
  );

  // Row of tap cells; the last one sees an empty neighbour.
  assign d_link[ORDER] = '0;

  for (genvar i = 0; i < ORDER; i++) begin : g_tap
    iirt_tap_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctrl    (ctrl),
      .x_in    (in_sample_in),
      .y_in    (out_sample_out),
      .ff_coef (ff_coef_r[i+1]),
      .fb_coef (fb_coef_r[i+1]),
      .fb_en   (fb_en_r),
      .d_next  (d_link[i+1]),
      .d_out   (d_link[i])
    );
  end

endmodule

// File: rtl/core/iirt_checker.sv
// Port-level checks for the transposed IIR filter, bound to the top level.
module iirt_checker (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  iirt_pkg::sample_t    out_sample_out,
  input  logic                 out_saturated,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready
);
  import iirt_pkg::*;

  // A stalled result beat holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_sample_out)
      && $stable(out_saturated))
    else $error("result beat changed while stalled");

  // A clipped result sits at one of the range limits.
  a_sat_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_saturated |->
      out_sample_out == SAMPLE_MAX || out_sample_out == SAMPLE_MIN)
    else $error("saturation flag set on an unclipped sample");

  // The delay update blocks a third sample beat in a row.
  a_rate: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) ##1 (in_valid && in_ready) |=> !in_ready)
    else $error("sample beat taken before the delay line was updated");

  // The register port never stalls.
  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid |-> cfg_ready)
    else $error("configuration write stalled");

endmodule

bind iir_filter_transposed_unit iirt_checker u_iirt_checker (.*);

// File: verif/tb.sv
// Self-checking testbench for the transposed direct form II IIR filter unit.
`timescale 1ns / 100ps

module tb;
  import iirt_pkg::*;

  // Timing of the run.
  localparam int  DRAIN_CYCLES = 8;
  localparam int  HOLD_OFF_CYCLES = 300;
  localparam int  MAX_REPORTS = 10;
  localparam int  SEGMENT_ITEMS = 39;
  localparam int  SEGMENTS_PER_PHASE = 6;

  // Register indexes beyond the defined set; writes to them must be ignored.
  localparam reg_idx_t REG_SPARE_6 = 3'd6;
  localparam reg_idx_t REG_SPARE_7 = 3'd7;

  // Coefficient extremes in Q2.15.
  localparam coef_t COEF_MAX = 18'sh1ffff;
  localparam coef_t COEF_MIN = 18'sh20000;
  localparam coef_t COEF_LSB = 18'sd1;

  // Idle patterns of the random traffic.
  typedef enum logic [1:0] {
    SENDER_LIGHT,
    SENDER_HEAVY,
    NO_IDLE
  } idle_mode_e;

  typedef struct {
    sample_t level;
    logic    clipped;
  } filtered_t;

  logic    clk;
  logic    rst_n;
  logic    in_valid;
  logic    in_ready;
  sample_t in_sample_in;
  logic    out_valid;
  logic    out_ready;
  sample_t out_sample_out;
  logic    out_saturated;
  logic    cfg_valid;
  logic    cfg_ready;
  reg_idx_t cfg_index;
  coef_t   cfg_data;

  // Filter state mirrored by the predictor.
  coef_t   ff_coef [0:2];
  coef_t   fb_coef [0:2];
  logic    fb_on;
  delay_t  tap_state [0:ORDER-1];

  filtered_t pending_outputs [$];

  int in_gap_pct;
  int out_stall_pct;
  int stall_left;
  int fail_count;
  int samples_taken;
  int results_checked;
  int clipped_results;
  int cfg_writes;

  iir_filter_transposed_unit DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_sample_in   (in_sample_in),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_sample_out (out_sample_out),
    .out_saturated  (out_saturated),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  // Clock with an 8 ns period.
  always #4 clk = ~clk;

  // One filter step: rounded and clipped output, then the delay line update.
  function automatic filtered_t filter_next(input sample_t x);
    longint    xs;
    longint    acc;
    longint    yv;
    longint    v;
    int        k;
    filtered_t r;
    xs = x;
    acc = longint'(ff_coef[0]) * xs + longint'(tap_state[0]);
    yv = (acc + (longint'(1) <<< (FRAC_SHIFT - 1))) >>> FRAC_SHIFT;
    r.clipped = 1'b0;
    if (yv > longint'(SAMPLE_MAX)) begin
      yv = SAMPLE_MAX;
      r.clipped = 1'b1;
    end else if (yv < longint'(SAMPLE_MIN)) begin
      yv = SAMPLE_MIN;
      r.clipped = 1'b1;
    end
    for (k = 0; k < ORDER; k++) begin
      v = longint'(ff_coef[k+1]) * xs;
      if (fb_on) begin
        v -= longint'(fb_coef[k+1]) * yv;
      end
      if (k + 1 < ORDER) begin
        v += longint'(tap_state[k+1]);
      end
      if (v > longint'(DELAY_MAX)) begin
        tap_state[k] = DELAY_MAX;
      end else if (v < longint'(DELAY_MIN)) begin
        tap_state[k] = DELAY_MIN;
      end else begin
        tap_state[k] = delay_t'(v);
      end
    end
    r.level = sample_t'(yv);
    return r;
  endfunction

  // Samples: mostly full range, with extremes and small values mixed in.
  function automatic sample_t pick_sample();
    case ($urandom_range(0, 9))
      0: return SAMPLE_MAX;
      1: return SAMPLE_MIN;
      2: return sample_t'(int'($urandom_range(0, 511)) - 256);
      default: return sample_t'($urandom);
    endcase
  endfunction

  // Coefficients: extremes, zero, gentle values and full range.
  function automatic coef_t pick_coef();
    case ($urandom_range(0, 7))
      0: return COEF_MAX;
      1: return COEF_MIN;
      2: return '0;
      3, 4, 5: return coef_t'(int'($urandom_range(0, 16383)) - 8192);
      default: return coef_t'($urandom);
    endcase
  endfunction

  // Offer one sample beat and wait until it is taken. Valid is left high on
  // return; the caller either offers the next beat or calls wait_idle.
  task automatic send_sample(input sample_t x);
    if ($urandom_range(0, 99) < in_gap_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < in_gap_pct);
    end
    in_valid     <= 1'b1;
    in_sample_in <= x;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Write one register and mirror it in the predictor.
  task automatic cfg_write(input reg_idx_t idx, input coef_t data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_FF_COEF_0: ff_coef[0] = data;
      REG_FF_COEF_1: ff_coef[1] = data;
      REG_FF_COEF_2: ff_coef[2] = data;
      REG_FB_COEF_1: fb_coef[1] = data;
      REG_FB_COEF_2: fb_coef[2] = data;
      REG_FB_ENABLE: fb_on = data[0];
      default: ;
    endcase
    cfg_writes++;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Stop offering, wait for every expected result, then let the pipe settle.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_outputs.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // After reset b0 is 1.0 and every other term is zero, so the output follows
  // the input exactly.
  task automatic test_identity_after_reset();
    send_sample('0);
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MIN);
    send_sample(sample_t'(-1));
    send_sample(16'sh5555);
    send_sample(16'shaaaa);
    wait_idle();
  endtask

  // Round half up at the smallest gain, then clipping in both directions at
  // the largest positive and negative gains.
  task automatic test_rounding_and_clipping();
    cfg_write(REG_FF_COEF_0, COEF_LSB);
    send_sample(16'sd16384);
    send_sample(-16'sd16384);
    send_sample(16'sd16383);
    send_sample(-16'sd16385);
    wait_idle();
    cfg_write(REG_FF_COEF_0, COEF_MAX);
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MIN);
    wait_idle();
    cfg_write(REG_FF_COEF_0, COEF_MIN);
    send_sample(SAMPLE_MIN);
    send_sample(SAMPLE_MAX);
    wait_idle();
  endtask

  // With feedback off the large feedback coefficients must have no effect.
  // The enable is written with its upper bits set to show they are ignored.
  task automatic test_fir_ignores_feedback();
    cfg_write(REG_FF_COEF_0, 18'sd16384);
    cfg_write(REG_FF_COEF_1, COEF_MIN);
    cfg_write(REG_FF_COEF_2, COEF_MAX);
    cfg_write(REG_FB_COEF_1, COEF_MAX);
    cfg_write(REG_FB_COEF_2, COEF_MIN);
    cfg_write(REG_FB_ENABLE, 18'sh1fffe);
    send_sample(SAMPLE_MAX);
    send_sample('0);
    send_sample(SAMPLE_MIN);
    send_sample('0);
    wait_idle();
  endtask

  // A lightly damped resonator driven by a short step, so the output rings
  // through the feedback path.
  task automatic test_iir_resonator();
    cfg_write(REG_FF_COEF_0, 18'sd4096);
    cfg_write(REG_FF_COEF_1, 18'sd8192);
    cfg_write(REG_FF_COEF_2, 18'sd4096);
    cfg_write(REG_FB_COEF_1, -18'sd59000);
    cfg_write(REG_FB_COEF_2, 18'sd28000);
    cfg_write(REG_FB_ENABLE, 18'sd1);
    repeat (3) send_sample(16'sd12000);
    repeat (5) send_sample('0);
    wait_idle();
  endtask

  // Writes to indexes beyond the register set change nothing.
  task automatic test_spare_indexes();
    cfg_write(REG_SPARE_6, coef_t'($urandom));
    cfg_write(REG_SPARE_7, COEF_MAX);
    send_sample(16'sd1000);
    send_sample(-16'sd1000);
    wait_idle();
  endtask

  // The receiver holds off for a long stretch while samples keep coming, so
  // the block fills and drops in_ready until the results are taken.
  task automatic test_backpressure();
    int n;
    in_gap_pct    = 0;
    out_stall_pct = 0;
    @(negedge clk);
    stall_left = HOLD_OFF_CYCLES;
    @(posedge clk);
    for (n = 0; n < 24; n++) begin
      send_sample(pick_sample());
    end
    wait_idle();
  endtask

  // Random samples under three idle patterns, reconfigured between segments.
  task automatic test_random_traffic();
    int phase;
    int seg;
    int n;
    idle_mode_e mode;
    for (phase = 0; phase < 3; phase++) begin
      mode = idle_mode_e'(phase);
      case (mode)
        SENDER_LIGHT: begin
          in_gap_pct    = 32;
          out_stall_pct = 77;
        end
        SENDER_HEAVY: begin
          in_gap_pct    = 77;
          out_stall_pct = 32;
        end
        default: begin
          in_gap_pct    = 0;
          out_stall_pct = 0;
        end
      endcase
      for (seg = 0; seg < SEGMENTS_PER_PHASE; seg++) begin
        cfg_write(REG_FF_COEF_0, pick_coef());
        cfg_write(REG_FF_COEF_1, pick_coef());
        cfg_write(REG_FF_COEF_2, pick_coef());
        cfg_write(REG_FB_COEF_1, pick_coef());
        cfg_write(REG_FB_COEF_2, pick_coef());
        cfg_write(REG_FB_ENABLE, coef_t'($urandom));
        for (n = 0; n < SEGMENT_ITEMS; n++) begin
          send_sample(pick_sample());
        end
        wait_idle();
      end
    end
  endtask

  // Receiver: random stalls, or a forced hold-off while stall_left runs.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left = stall_left - 1;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= out_stall_pct);
    end
  end

  // Check each result beat against the oldest expectation, then predict the
  // result of any sample beat taken at the same edge.
  always @(posedge clk) begin
    filtered_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        results_checked++;
        if (out_saturated) begin
          clipped_results++;
        end
        if (pending_outputs.size() == 0) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS) begin
            $display("unexpected result beat: sample %0d saturated %0b",
                     out_sample_out, out_saturated);
          end
        end else begin
          want = pending_outputs.pop_front();
          if (out_sample_out !== want.level || out_saturated !== want.clipped) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS) begin
              $display("mismatch at result %0d: expected sample %0d saturated %0b,",
                       results_checked, want.level, want.clipped);
              $display("  got sample %0d saturated %0b", out_sample_out, out_saturated);
            end
          end
        end
      end
      if (in_valid && in_ready) begin
        samples_taken++;
        pending_outputs.push_back(filter_next(in_sample_in));
      end
    end
  end

  // Sequence of tests.
  initial begin
    clk           = 1'b0;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_sample_in  = '0;
    cfg_valid     = 1'b0;
    cfg_index     = REG_FF_COEF_0;
    cfg_data      = '0;
    in_gap_pct    = 10;
    out_stall_pct = 10;
    stall_left    = 0;
    fail_count    = 0;
    samples_taken = 0;
    results_checked = 0;
    clipped_results = 0;
    cfg_writes    = 0;
    ff_coef[0]    = FF_COEF_0_RESET;
    ff_coef[1]    = '0;
    ff_coef[2]    = '0;
    fb_coef[0]    = '0;
    fb_coef[1]    = '0;
    fb_coef[2]    = '0;
    fb_on         = 1'b1;
    for (int k = 0; k < ORDER; k++) begin
      tap_state[k] = '0;
    end
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_identity_after_reset();
    test_rounding_and_clipping();
    test_fir_ignores_feedback();
    test_iir_resonator();
    test_spare_indexes();
    test_backpressure();
    test_random_traffic();

    if (pending_outputs.size() != 0) begin
      fail_count++;
      $display("%0d expected results never arrived", pending_outputs.size());
    end
    $display("Covered %0d samples and %0d results (%0d clipped) over %0d register writes,",
             samples_taken, results_checked, clipped_results, cfg_writes);
    $display("  under three idle patterns and a %0d cycle output hold-off; %0d failures.",
             HOLD_OFF_CYCLES, fail_count);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #3000000;
    $display("status: fail");
    $finish;
  end

endmodule
